// ===== design/idwpc_pkg.sv =====
// ----------------------------------------------------------------------------
// idwpc_pkg
// Shared constants for the inverse-distance-weighted point correction block.
// ----------------------------------------------------------------------------
package idwpc_pkg;

  // Fraction bits of the relative weights.
  localparam int WEIGHT_BITS = 28;

  // Function codes of an input word.
  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_CORRECT = 1'b1;

  // Status codes of a result word.
  localparam logic STATUS_OK         = 1'b0;
  localparam logic STATUS_COINCIDENT = 1'b1;

endpackage

// ===== design/idwpc_if.sv =====
// ----------------------------------------------------------------------------
// idwpc_if
// Valid/ready channels for the input and result words of the block.
// ----------------------------------------------------------------------------
interface idwpc_in_if #(parameter int COORD_BITS = 24) ();
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [2:0]                   entry_index;
  logic signed [COORD_BITS-1:0] ref_x;
  logic signed [COORD_BITS-1:0] ref_y;
  logic signed [COORD_BITS-1:0] offset_x;
  logic signed [COORD_BITS-1:0] offset_y;
  logic signed [COORD_BITS-1:0] target_x;
  logic signed [COORD_BITS-1:0] target_y;

  modport source (output valid, func, entry_index, ref_x, ref_y, offset_x, offset_y,
                  target_x, target_y, input ready);
  modport sink (input valid, func, entry_index, ref_x, ref_y, offset_x, offset_y,
                target_x, target_y, output ready);
endinterface

interface idwpc_out_if #(parameter int COORD_BITS = 24) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] moved_x;
  logic signed [COORD_BITS-1:0] moved_y;
  logic [COORD_BITS-1:0]        shift_length;
  logic                         status;

  modport source (output valid, moved_x, moved_y, shift_length, status, input ready);
  modport sink (input valid, moved_x, moved_y, shift_length, status, output ready);
endinterface

// ===== design/idwpc_table.sv =====
// ----------------------------------------------------------------------------
// idwpc_table
// Registration table: one synchronous memory of point and offset entries with
// a registered read port and per-entry valid bits that make reset read zero.
// ----------------------------------------------------------------------------
module idwpc_table #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 96
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] rd_data_r;

  // Storage array, no reset.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Valid bits: an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data_r <= vld_r[rd_addr] ? mem[rd_addr] : '0;
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/idwpc_sqrt.sv =====
// ----------------------------------------------------------------------------
// idwpc_sqrt
// Restoring square root, one root bit per cycle, rounded to nearest.
// ----------------------------------------------------------------------------
module idwpc_sqrt #(
  parameter int RB = 25
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [2*RB-1:0] radicand,
  output logic            busy,
  output logic            done,
  output logic [RB-1:0]   root
);

  logic [2*RB-1:0]          rad_r;
  logic [RB-1:0]            root_r;
  logic [RB+1:0]            rem_r;
  logic [$clog2(RB+1)-1:0]  cnt_r;
  logic                     busy_r;
  logic                     done_r;
  logic [RB+3:0]            rem_sh;
  logic [RB+3:0]            trial;
  logic                     ge;

  // One trial subtraction per step.
  always_comb begin
    rem_sh = {rem_r, rad_r[2*RB-1 -: 2]};
    trial  = {2'b00, root_r, 2'b01};
    ge     = (rem_sh >= trial);
  end

  // Control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= ($clog2(RB+1))'(RB);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == ($clog2(RB+1))'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      root_r <= '0;
      rem_r  <= '0;
    end else if (busy_r) begin
      rad_r  <= rad_r << 2;
      root_r <= {root_r[RB-2:0], ge};
      rem_r  <= ge ? (RB+2)'(rem_sh - trial) : rem_sh[RB+1:0];
    end
  end

  // Round up when the remainder exceeds the floor root.
  assign root = root_r + RB'(rem_r > {2'b00, root_r});
  assign busy = busy_r;
  assign done = done_r;

endmodule

// ===== design/idwpc_div.sv =====
// ----------------------------------------------------------------------------
// idwpc_div
// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in QB bits.
// ----------------------------------------------------------------------------
module idwpc_div #(
  parameter int NW = 56,
  parameter int DW = 32,
  parameter int QB = 29
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic          done,
  output logic [QB-1:0] quo
);

  logic [DW-1:0]            rem_r;
  logic [DW-1:0]            den_r;
  logic [QB-1:0]            low_r;
  logic [$clog2(QB+1)-1:0]  cnt_r;
  logic                     busy_r;
  logic                     done_r;
  logic [DW:0]              t;
  logic                     ge;

  always_comb begin
    t  = {rem_r, low_r[QB-1]};
    ge = (t >= {1'b0, den_r});
  end

  // Control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= ($clog2(QB+1))'(QB);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == ($clog2(QB+1))'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits shift into the low numerator register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DW'(num >> QB);
      low_r <= num[QB-1:0];
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? DW'(t - {1'b0, den_r}) : t[DW-1:0];
      low_r <= {low_r[QB-2:0], ge};
    end
  end

  assign quo  = low_r;
  assign busy = busy_r;
  assign done = done_r;

endmodule

// ===== design/idw_point_correction_top.sv =====
// ----------------------------------------------------------------------------
// idw_point_correction_top
// Inverse-distance-weighted point correction over a small registration table.
//
//   Channel  | Dir | Word
//   in_ch    | in  | func, entry_index, ref/offset point (load), target point
//   out_ch   | out | moved_x, moved_y, shift_length, status (one per correct)
//
// A load word is written in the cycle it is accepted. A correct word first finds per
// entry its distance to the target (table read, two squares, the bit-serial square
// root). It then forms per entry the weight (a serial division and two products),
// runs the two quotient divisions and one more root for the shift length. A target
// on exactly one entry takes that entry's offset in place of the weighting; on two
// or more it is passed on unmoved with status coincident.
// Reset is synchronous and clears the table to zero through its valid bits.
// The output register holds a result while out_ch stalls; a new word is taken
// meanwhile, and a finished correction waits for the register to drain.
// ----------------------------------------------------------------------------
module idw_point_correction_top #(
  parameter int NUM_REF_POINTS = 4,
  parameter int COORD_BITS     = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  idwpc_in_if.sink    in_ch,
  idwpc_out_if.source out_ch
);

  localparam int C    = COORD_BITS;
  localparam int IW   = $clog2(NUM_REF_POINTS);
  localparam int ZW   = $clog2(NUM_REF_POINTS + 1);
  localparam int RB   = C + 1;
  localparam int WB   = idwpc_pkg::WEIGHT_BITS + 1;
  localparam int QB   = (C > WB) ? C : WB;
  localparam int DW   = (RB > 32) ? RB : 32;
  localparam int NW   = C + 32;
  localparam int PW   = WB + 1 + C;
  localparam int SW   = C + 1;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_RD   = 5'd1;
  localparam logic [4:0] S_SQX  = 5'd2;
  localparam logic [4:0] S_SQY  = 5'd3;
  localparam logic [4:0] S_SQS  = 5'd4;
  localparam logic [4:0] S_SQW  = 5'd5;
  localparam logic [4:0] S_BR   = 5'd6;
  localparam logic [4:0] S_ZRD  = 5'd7;
  localparam logic [4:0] S_ZOFF = 5'd8;
  localparam logic [4:0] S_WDS  = 5'd9;
  localparam logic [4:0] S_WDW  = 5'd10;
  localparam logic [4:0] S_WMX  = 5'd11;
  localparam logic [4:0] S_WMY  = 5'd12;
  localparam logic [4:0] S_WAC  = 5'd13;
  localparam logic [4:0] S_XDS  = 5'd14;
  localparam logic [4:0] S_XDW  = 5'd15;
  localparam logic [4:0] S_YDS  = 5'd16;
  localparam logic [4:0] S_YDW  = 5'd17;
  localparam logic [4:0] S_MOVE = 5'd18;
  localparam logic [4:0] S_OUT  = 5'd19;

  logic [4:0]             state_r;
  logic                   in_acc;
  logic                   load_ok;

  logic                   tbl_we;
  logic [IW-1:0]          tbl_raddr;
  logic [4*C-1:0]         tbl_rdata;
  logic signed [C-1:0]    rd_px, rd_py, rd_ox, rd_oy;

  logic signed [C-1:0]    tx_r, ty_r;
  logic [IW-1:0]          idx_r;
  logic                   lenph_r;
  logic [2*RB-1:0]        acc_r;
  logic [RB-1:0]          dist_r [NUM_REF_POINTS];
  logic [RB-1:0]          dmin_r;
  logic [ZW-1:0]          zcnt_r;
  logic [IW-1:0]          zidx_r;
  logic [WB-1:0]          r_r;
  logic [DW-1:0]          den_r;
  logic signed [NW-1:0]   nx_r, ny_r;
  logic signed [PW-1:0]   prod_r;
  logic signed [SW-1:0]   sx_r, sy_r;
  logic signed [C-1:0]    mx_r, my_r;
  logic                   status_r;
  logic [C-1:0]           len_r;

  logic                   out_valid_r;
  logic signed [C-1:0]    out_mx_r, out_my_r;
  logic [C-1:0]           out_len_r;
  logic                   out_status_r;

  logic signed [C-1:0]    ax, ay;
  logic signed [C:0]      dx, dy;
  logic [C:0]             dxm, dym;

  logic                   sq_start, sq_busy, sq_done;
  logic [RB-1:0]          sq_root;
  logic                   div_start, div_busy, div_done;
  logic [NW-1:0]          div_num;
  logic [DW-1:0]          div_den;
  logic [QB-1:0]          div_quo;
  logic [NW-1:0]          nx_mag, ny_mag;
  logic signed [SW-1:0]   q_s;
  logic signed [C+1:0]    sumx, sumy;
  logic signed [C-1:0]    satx, saty;
  logic signed [C+1:0]    cmax, cmin;

  // Handshake on the input word.
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign load_ok     = ({1'b0, in_ch.entry_index} < 4'(NUM_REF_POINTS));
  assign tbl_we      = in_acc && (in_ch.func == idwpc_pkg::FUNC_LOAD) && load_ok;
  assign tbl_raddr   = (state_r == S_ZRD || state_r == S_ZOFF) ? zidx_r : idx_r;

  idwpc_table #(.DEPTH(NUM_REF_POINTS), .WIDTH(4*C)) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (tbl_we),
    .wr_addr (in_ch.entry_index[IW-1:0]),
    .wr_data ({in_ch.ref_x, in_ch.ref_y, in_ch.offset_x, in_ch.offset_y}),
    .rd_addr (tbl_raddr),
    .rd_data (tbl_rdata)
  );

  assign rd_px = $signed(tbl_rdata[4*C-1 -: C]);
  assign rd_py = $signed(tbl_rdata[3*C-1 -: C]);
  assign rd_ox = $signed(tbl_rdata[2*C-1 -: C]);
  assign rd_oy = $signed(tbl_rdata[C-1 -: C]);

  // Differences from the target and their magnitudes.
  always_comb begin
    ax  = lenph_r ? mx_r : rd_px;
    ay  = lenph_r ? my_r : rd_py;
    dx  = {ax[C-1], ax} - {tx_r[C-1], tx_r};
    dy  = {ay[C-1], ay} - {ty_r[C-1], ty_r};
    dxm = dx[C] ? (C+1)'(-dx) : (C+1)'(dx);
    dym = dy[C] ? (C+1)'(-dy) : (C+1)'(dy);
  end

  idwpc_sqrt #(.RB(RB)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (acc_r),
    .busy     (sq_busy),
    .done     (sq_done),
    .root     (sq_root)
  );

  // Divider operands: a weight, or one of the rounded offset quotients.
  always_comb begin
    nx_mag  = nx_r[NW-1] ? NW'(-nx_r) : NW'(nx_r);
    ny_mag  = ny_r[NW-1] ? NW'(-ny_r) : NW'(ny_r);
    div_num = NW'(dmin_r) << idwpc_pkg::WEIGHT_BITS;
    div_den = DW'(dist_r[idx_r]);
    if (state_r == S_XDS) begin
      div_num = nx_mag + NW'(den_r >> 1);
      div_den = den_r;
    end else if (state_r == S_YDS) begin
      div_num = ny_mag + NW'(den_r >> 1);
      div_den = den_r;
    end
  end

  assign sq_start  = (state_r == S_SQS);
  assign div_start = (state_r == S_WDS) || (state_r == S_XDS) || (state_r == S_YDS);

  idwpc_div #(.NW(NW), .DW(DW), .QB(QB)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Signed quotient and the saturated moved point.
  always_comb begin
    q_s  = (state_r == S_XDW) ? (nx_r[NW-1] ? -$signed(SW'(div_quo)) : $signed(SW'(div_quo)))
                              : (ny_r[NW-1] ? -$signed(SW'(div_quo)) : $signed(SW'(div_quo)));
    cmax = (C+2)'({1'b0, {(C-1){1'b1}}});
    cmin = -cmax - (C+2)'(1);
    sumx = (C+2)'(tx_r) + (C+2)'(sx_r);
    sumy = (C+2)'(ty_r) + (C+2)'(sy_r);
    satx = (sumx > cmax) ? C'(cmax) : ((sumx < cmin) ? C'(cmin) : C'(sumx));
    saty = (sumy > cmax) ? C'(cmax) : ((sumy < cmin) ? C'(cmin) : C'(sumy));
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      lenph_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_ch.func == idwpc_pkg::FUNC_CORRECT) begin
            state_r <= S_RD;
            lenph_r <= 1'b0;
          end
        end
        S_RD:   state_r <= S_SQX;
        S_SQX:  state_r <= S_SQY;
        S_SQY:  state_r <= S_SQS;
        S_SQS:  state_r <= S_SQW;
        S_SQW: begin
          if (sq_done) begin
            if (lenph_r) begin
              state_r <= S_OUT;
            end else if (idx_r == IW'(NUM_REF_POINTS - 1)) begin
              state_r <= S_BR;
            end else begin
              state_r <= S_RD;
            end
          end
        end
        S_BR: begin
          if (zcnt_r >= ZW'(2)) begin
            state_r <= S_MOVE;
          end else if (zcnt_r == ZW'(1)) begin
            state_r <= S_ZRD;
          end else begin
            state_r <= S_WDS;
          end
        end
        S_ZRD:  state_r <= S_ZOFF;
        S_ZOFF: state_r <= S_MOVE;
        S_WDS:  state_r <= S_WDW;
        S_WDW: begin
          if (div_done) begin
            state_r <= S_WMX;
          end
        end
        S_WMX:  state_r <= S_WMY;
        S_WMY:  state_r <= S_WAC;
        S_WAC:  state_r <= (idx_r == IW'(NUM_REF_POINTS - 1)) ? S_XDS : S_WDS;
        S_XDS:  state_r <= S_XDW;
        S_XDW: begin
          if (div_done) begin
            state_r <= S_YDS;
          end
        end
        S_YDS:  state_r <= S_YDW;
        S_YDW: begin
          if (div_done) begin
            state_r <= S_MOVE;
          end
        end
        S_MOVE: begin
          state_r <= S_SQX;
          lenph_r <= 1'b1;
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            state_r <= S_IDLE;
            lenph_r <= 1'b0;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Item datapath.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        tx_r     <= in_ch.target_x;
        ty_r     <= in_ch.target_y;
        idx_r    <= '0;
        dmin_r   <= '0;
        zcnt_r   <= '0;
        zidx_r   <= '0;
        status_r <= idwpc_pkg::STATUS_OK;
        sx_r     <= '0;
        sy_r     <= '0;
      end
      S_SQX: acc_r <= (2*RB)'(dxm * dxm);
      S_SQY: acc_r <= acc_r + (2*RB)'(dym * dym);
      S_SQW: begin
        if (sq_done && !lenph_r) begin
          dist_r[idx_r] <= sq_root;
          if (sq_root == '0) begin
            zcnt_r <= zcnt_r + 1'b1;
            zidx_r <= idx_r;
          end else if (dmin_r == '0 || sq_root < dmin_r) begin
            dmin_r <= sq_root;
          end
          if (idx_r != IW'(NUM_REF_POINTS - 1)) begin
            idx_r <= idx_r + 1'b1;
          end
        end
      end
      S_BR: begin
        idx_r <= '0;
        den_r <= '0;
        nx_r  <= '0;
        ny_r  <= '0;
        if (zcnt_r >= ZW'(2)) begin
          status_r <= idwpc_pkg::STATUS_COINCIDENT;
        end
      end
      S_ZOFF: begin
        sx_r <= SW'(rd_ox);
        sy_r <= SW'(rd_oy);
      end
      S_WDW: begin
        if (div_done) begin
          r_r   <= div_quo[WB-1:0];
          den_r <= den_r + DW'(div_quo);
        end
      end
      S_WMX: prod_r <= $signed({1'b0, r_r}) * rd_ox;
      S_WMY: begin
        nx_r   <= nx_r + NW'(prod_r);
        prod_r <= $signed({1'b0, r_r}) * rd_oy;
      end
      S_WAC: begin
        ny_r <= ny_r + NW'(prod_r);
        if (idx_r != IW'(NUM_REF_POINTS - 1)) begin
          idx_r <= idx_r + 1'b1;
        end
      end
      S_XDW: begin
        if (div_done) begin
          sx_r <= q_s;
        end
      end
      S_YDW: begin
        if (div_done) begin
          sy_r <= q_s;
        end
      end
      S_MOVE: begin
        mx_r <= satx;
        my_r <= saty;
      end
      default: ;
    endcase
  end

  // Output register; the shift length is clamped to the field range.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && (!out_valid_r || out_ch.ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // The shift length waits beside the datapath until the output register is free.
  always_ff @(posedge clk) begin
    if (state_r == S_SQW && sq_done && lenph_r) begin
      len_r <= sq_root[C] ? {C{1'b1}} : sq_root[C-1:0];
    end
    if (state_r == S_OUT && (!out_valid_r || out_ch.ready)) begin
      out_mx_r     <= mx_r;
      out_my_r     <= my_r;
      out_len_r    <= len_r;
      out_status_r <= status_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.moved_x      = out_mx_r;
  assign out_ch.moved_y      = out_my_r;
  assign out_ch.shift_length = out_len_r;
  assign out_ch.status       = out_status_r;

  // The shared units are never restarted while still working.
  a_sqrt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    sq_start |-> !sq_busy)
    else $error("square root started while busy");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // A coincident target is passed on without any move.
  a_coincident: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == idwpc_pkg::STATUS_COINCIDENT) |-> (out_len_r == '0))
    else $error("coincident result reports a nonzero shift");

endmodule
